>>> rtl/vec2_arith_unit_defines.svh
// Assertion macros for the vec2_arith_unit checker.
// Used only by the checker file; needs nothing else.
`ifndef VEC2_ARITH_UNIT_DEFINES_SVH
`define VEC2_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define V2A_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vec2_arith_unit check failed");

// Next-cycle implication, disabled while reset is asserted
`define V2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vec2_arith_unit check failed");

`endif

>>> rtl/v2a_pkg.sv
// Shared types and constants of the 2D vector ALU.
// No dependencies; the lane, top level and checker refer to it by scoped names.
`timescale 1ns / 1ps

package v2a_pkg;

    // Port field geometry
    localparam int FIELD_BITS    = 32;
    localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 3 * FIELD_BITS;
    localparam int OUT_USER_BITS = 2;
    localparam int OUT_DZ_BIT    = 0;
    localparam int OUT_SAT_BIT   = 1;

    // Operation codes
    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_NEG  = 3'd4,
        CMD_DOT  = 3'd5,
        CMD_LEN  = 3'd6,
        CMD_NORM = 3'd7
    } cmd_t;

    // Stage control: valid bit and operation
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } ctrl_t;

endpackage

>>> rtl/v2a_lane.sv
// One component lane: magnitudes, products, squares and saturated add/sub/negate.
// Depends on v2a_pkg for the operation codes.
`timescale 1ns / 1ps

module v2a_lane #(
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  v2a_pkg::cmd_t            cmd,
    input  logic [WORD_BITS-1:0]     a,
    input  logic [WORD_BITS-1:0]     b,
    output logic [WORD_BITS-1:0]     mag_a,
    output logic [WORD_BITS-1:0]     mag_b,
    output logic                     neg_a,
    output logic                     neg_b,
    output logic [2*WORD_BITS-1:0]   prod,
    output logic [2*WORD_BITS-1:0]   sq,
    output logic [WORD_BITS-1:0]     lin_res,
    output logic                     lin_sat
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_VAL = ~MIN_VAL;

    logic [W-1:0]   ma_c;
    logic [W-1:0]   mb_c;
    logic [W:0]     a_ext;
    logic [W:0]     b_ext;
    logic [W:0]     lin_c;
    logic           ovf_c;
    logic [W-1:0]   lin_res_c;

    logic [W-1:0]   mag_a_reg;
    logic [W-1:0]   mag_b_reg;
    logic           neg_a_reg;
    logic           neg_b_reg;
    logic [2*W-1:0] prod_reg;
    logic [2*W-1:0] sq_reg;
    logic [W-1:0]   lin_res_reg;
    logic           lin_sat_reg;

    // Magnitudes; the most negative word maps to 2^(W-1)
    always_comb
    begin
        ma_c  = a[W-1] ? (~a + 1'b1) : a;
        mb_c  = b[W-1] ? (~b + 1'b1) : b;
        a_ext = {a[W-1], a};
        b_ext = {b[W-1], b};
    end

    // Add, subtract, negate one bit wider, then clamp on overflow
    always_comb
    begin
        case (cmd)
            v2a_pkg::CMD_ADD: lin_c = a_ext + b_ext;
            v2a_pkg::CMD_SUB: lin_c = a_ext - b_ext;
            v2a_pkg::CMD_NEG: lin_c = ~a_ext + 1'b1;
            default:          lin_c = '0;
        endcase
        ovf_c     = lin_c[W] ^ lin_c[W-1];
        lin_res_c = ovf_c ? (lin_c[W] ? MIN_VAL : MAX_VAL) : lin_c[W-1:0];
    end

    // Lane registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg   <= ma_c;
            mag_b_reg   <= mb_c;
            neg_a_reg   <= a[W-1];
            neg_b_reg   <= b[W-1];
            prod_reg    <= (2*W)'(ma_c) * (2*W)'(mb_c);
            sq_reg      <= (2*W)'(ma_c) * (2*W)'(ma_c);
            lin_res_reg <= lin_res_c;
            lin_sat_reg <= ovf_c;
        end
    end

    assign mag_a   = mag_a_reg;
    assign mag_b   = mag_b_reg;
    assign neg_a   = neg_a_reg;
    assign neg_b   = neg_b_reg;
    assign prod    = prod_reg;
    assign sq      = sq_reg;
    assign lin_res = lin_res_reg;
    assign lin_sat = lin_sat_reg;

endmodule

>>> rtl/v2a_isqrt.sv
// Pipelined integer square root, one root bit per stage, WORD_BITS stages.
// Standalone; no package use.
`timescale 1ns / 1ps

module v2a_isqrt #(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [2*WORD_BITS-1:0] radicand,
    output logic [WORD_BITS-1:0]   root
);

    localparam int W = WORD_BITS;

    logic [2*W-1:0] x_reg   [W];
    logic [W:0]     rem_reg [W];
    logic [W-1:0]   r_reg   [W];

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [2*W-1:0] x_in;
        logic [W:0]     rem_in;
        logic [W-1:0]   r_in;
        logic [W+2:0]   rem_sh;
        logic [W+2:0]   trial;
        logic [W+2:0]   rem_sub;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign x_in   = radicand;
            assign rem_in = '0;
            assign r_in   = '0;
        end
        else
        begin : g_next
            assign x_in   = x_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign r_in   = r_reg[k-1];
        end

        // Bring down two radicand bits, try 4r+1
        always_comb
        begin
            rem_sh  = {rem_in, x_in[2*W-1 -: 2]};
            trial   = {1'b0, r_in, 2'b01};
            ge      = (rem_sh >= trial);
            rem_sub = rem_sh - trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_in << 2;
                rem_reg[k] <= ge ? rem_sub[W:0] : rem_sh[W:0];
                r_reg[k]   <= {r_in[W-2:0], ge};
            end
        end
    end

    assign root = r_reg[W-1];

endmodule

>>> rtl/v2a_div.sv
// Pipelined restoring divider: (dividend << FRAC_BITS) / divisor, one bit per stage.
// Standalone; no package use. A zero divisor gives a meaningless quotient.
`timescale 1ns / 1ps

module v2a_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [WORD_BITS-1:0]           dividend,
    input  logic [WORD_BITS-1:0]           divisor,
    output logic [WORD_BITS+FRAC_BITS-1:0] quotient
);

    localparam int W  = WORD_BITS;
    localparam int QB = WORD_BITS + FRAC_BITS;

    logic [QB-1:0] n_reg   [QB];
    logic [W-1:0]  d_reg   [QB];
    logic [W-1:0]  rem_reg [QB];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [QB-1:0] n_in;
        logic [W-1:0]  d_in;
        logic [W-1:0]  rem_in;
        logic [QB-1:0] q_in;
        logic [W:0]    rem_sh;
        logic [W:0]    rem_sub;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign n_in   = QB'(dividend) << FRAC_BITS;
            assign d_in   = divisor;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign n_in   = n_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // Shift in next numerator bit, subtract when it fits
        always_comb
        begin
            rem_sh  = {rem_in, n_in[QB-1]};
            ge      = (rem_sh >= {1'b0, d_in});
            rem_sub = rem_sh - {1'b0, d_in};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_in << 1;
                d_reg[k]   <= d_in;
                rem_reg[k] <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                q_reg[k]   <= {q_in[QB-2:0], ge};
            end
        end
    end

    assign quotient = q_reg[QB-1];

endmodule

>>> rtl/vec2_arith_unit.sv
// Throughput: one transfer per cycle; the pipeline stalls as a whole while a result waits.
// Depth is set by the square-root pipeline (WORD_BITS stages) followed by the per-lane
// dividers (WORD_BITS + FRAC_BITS stages). Reset clears only the control and valid
// registers; no clearing pass. Depends on v2a_pkg, v2a_lane, v2a_isqrt and v2a_div.
`timescale 1ns / 1ps

module vec2_arith_unit #(
    parameter int WORD_BITS = 32,   // 8..32
    parameter int FRAC_BITS = 16    // 0..31
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [v2a_pkg::IN_DATA_BITS-1:0]   s_tdata,   // ax, ay, bx, by
    input  logic [v2a_pkg::IN_USER_BITS-1:0]   s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [v2a_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // rx, ry, scalar
    output logic [v2a_pkg::OUT_USER_BITS-1:0]  m_tuser    // div_zero, saturated
);

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int FB    = v2a_pkg::FIELD_BITS;
    localparam int QB    = W + F;
    localparam int DW    = 2 * W + 2;
    localparam int MW    = (DW > QB) ? DW : QB;
    localparam int DEPTH = 2 * W + F + 1;
    localparam int LAST  = DEPTH - 1;
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_VAL = ~MIN_VAL;

    typedef struct packed {
        v2a_pkg::cmd_t         cmd;
        logic [W-1:0]          res_x;
        logic [W-1:0]          res_y;
        logic                  simple_sat;
        logic signed [DW-1:0]  dot_sum;
        logic [W-1:0]          mag_ax;
        logic [W-1:0]          mag_ay;
        logic [W-1:0]          mag_bx;
        logic [W-1:0]          mag_by;
        logic                  neg_ax;
        logic                  neg_ay;
        logic                  neg_bx;
        logic                  neg_by;
        logic [W-1:0]          root;
    } pay_t;

    // Sign and magnitude to clamped word; returns {sat, value}
    function automatic logic [W:0] clamp_sm(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] neg_mag;
        logic [MW-1:0] pos_mag;
        logic [W:0]    r;
        neg_mag = MW'(1) << (W - 1);
        pos_mag = neg_mag - 1'b1;
        if (neg)
        begin
            if (m > neg_mag)
                r = {1'b1, MIN_VAL};
            else
                r = {1'b0, ~m[W-1:0] + 1'b1};
        end
        else
        begin
            if (m > pos_mag)
                r = {1'b1, MAX_VAL};
            else
                r = {1'b0, m[W-1:0]};
        end
        return r;
    endfunction

    // Divide or normalize lane result; returns {div_zero, sat, value}
    function automatic logic [W+1:0] div_lane(
        input logic          is_norm,
        input logic [W-1:0]  mag_a,
        input logic          neg_a,
        input logic [W-1:0]  mag_b,
        input logic          neg_b,
        input logic [W-1:0]  root,
        input logic [QB-1:0] q
    );
        logic [W:0]   c;
        logic [W+1:0] r;
        c = clamp_sm(is_norm ? neg_a : (neg_a ^ neg_b), MW'(q));
        if (is_norm)
        begin
            // zero vector comes back unchanged, i.e. zero
            if (root == '0)
                r = '0;
            else
                r = {1'b0, c};
        end
        else if (mag_b == '0)
        begin
            if (mag_a == '0)
                r = {1'b1, 1'b0, {W{1'b0}}};
            else
                r = {1'b1, 1'b1, (neg_a ? MIN_VAL : MAX_VAL)};
        end
        else
        begin
            r = {1'b0, c};
        end
        return r;
    endfunction

    logic                 en;
    logic                 out_valid_reg;
    logic [FB-1:0]        rx_reg;
    logic [FB-1:0]        ry_reg;
    logic [FB-1:0]        sc_reg;
    logic                 dz_reg;
    logic                 sat_reg;

    v2a_pkg::ctrl_t       ctrl0_reg;
    v2a_pkg::ctrl_t       ctrl1_reg;
    logic [W-1:0]         ax0_reg;
    logic [W-1:0]         ay0_reg;
    logic [W-1:0]         bx0_reg;
    logic [W-1:0]         by0_reg;

    logic [W-1:0]         mag_ax;
    logic [W-1:0]         mag_bx;
    logic [W-1:0]         mag_ay;
    logic [W-1:0]         mag_by;
    logic                 neg_ax;
    logic                 neg_bx;
    logic                 neg_ay;
    logic                 neg_by;
    logic [2*W-1:0]       prod_x;
    logic [2*W-1:0]       prod_y;
    logic [2*W-1:0]       sq_x;
    logic [2*W-1:0]       sq_y;
    logic [W-1:0]         lin_x;
    logic [W-1:0]         lin_y;
    logic                 lin_sat_x;
    logic                 lin_sat_y;

    logic [W:0]           mul_x_c;
    logic [W:0]           mul_y_c;
    logic [DW-1:0]        px_c;
    logic [DW-1:0]        py_c;
    pay_t                 s2_c;
    logic [2*W-1:0]       sqsum_reg;

    pay_t                 pay_reg [DEPTH];
    pay_t                 pay_root_c;
    logic [DEPTH-1:0]     vld_reg;
    logic [W-1:0]         root_w;
    logic [W-1:0]         div_d_x;
    logic [W-1:0]         div_d_y;
    logic [QB-1:0]        quo_x;
    logic [QB-1:0]        quo_y;

    pay_t                 fin;
    logic [W+1:0]         div_x_c;
    logic [W+1:0]         div_y_c;
    logic [DW-1:0]        dot_mag_c;
    logic [W:0]           dot_c;
    logic [W:0]           len_c;
    logic [W-1:0]         rx_c;
    logic [W-1:0]         ry_c;
    logic [W-1:0]         sc_c;
    logic                 dz_c;
    logic                 sat_c;

    // Whole pipeline moves unless a result is held at the output
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg <= '0;
            ctrl1_reg <= '0;
        end
        else if (en)
        begin
            ctrl0_reg.valid <= s_tvalid;
            ctrl0_reg.cmd   <= v2a_pkg::cmd_t'(s_tuser);
            ctrl1_reg       <= ctrl0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax0_reg <= s_tdata[W-1:0];
            ay0_reg <= s_tdata[FB+W-1:FB];
            bx0_reg <= s_tdata[2*FB+W-1:2*FB];
            by0_reg <= s_tdata[3*FB+W-1:3*FB];
        end
    end

    // Component lanes
    v2a_lane #(.WORD_BITS(W)) u_lane_x (
        .clk     (clk),
        .en      (en),
        .cmd     (ctrl0_reg.cmd),
        .a       (ax0_reg),
        .b       (bx0_reg),
        .mag_a   (mag_ax),
        .mag_b   (mag_bx),
        .neg_a   (neg_ax),
        .neg_b   (neg_bx),
        .prod    (prod_x),
        .sq      (sq_x),
        .lin_res (lin_x),
        .lin_sat (lin_sat_x)
    );

    v2a_lane #(.WORD_BITS(W)) u_lane_y (
        .clk     (clk),
        .en      (en),
        .cmd     (ctrl0_reg.cmd),
        .a       (ay0_reg),
        .b       (by0_reg),
        .mag_a   (mag_ay),
        .mag_b   (mag_by),
        .neg_a   (neg_ay),
        .neg_b   (neg_by),
        .prod    (prod_y),
        .sq      (sq_y),
        .lin_res (lin_y),
        .lin_sat (lin_sat_y)
    );

    // Merge stage: multiply clamp, signed dot sum
    always_comb
    begin
        mul_x_c = clamp_sm(neg_ax ^ neg_bx, MW'(prod_x >> F));
        mul_y_c = clamp_sm(neg_ay ^ neg_by, MW'(prod_y >> F));
        px_c    = (neg_ax ^ neg_bx) ? (~DW'(prod_x) + 1'b1) : DW'(prod_x);
        py_c    = (neg_ay ^ neg_by) ? (~DW'(prod_y) + 1'b1) : DW'(prod_y);

        s2_c.cmd = ctrl1_reg.cmd;
        if (ctrl1_reg.cmd == v2a_pkg::CMD_MUL)
        begin
            s2_c.res_x      = mul_x_c[W-1:0];
            s2_c.res_y      = mul_y_c[W-1:0];
            s2_c.simple_sat = mul_x_c[W] | mul_y_c[W];
        end
        else
        begin
            s2_c.res_x      = lin_x;
            s2_c.res_y      = lin_y;
            s2_c.simple_sat = lin_sat_x | lin_sat_y;
        end
        s2_c.dot_sum = px_c + py_c;
        s2_c.mag_ax  = mag_ax;
        s2_c.mag_ay  = mag_ay;
        s2_c.mag_bx  = mag_bx;
        s2_c.mag_by  = mag_by;
        s2_c.neg_ax  = neg_ax;
        s2_c.neg_ay  = neg_ay;
        s2_c.neg_bx  = neg_bx;
        s2_c.neg_by  = neg_by;
        s2_c.root    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqsum_reg  <= sq_x + sq_y;
            pay_reg[0] <= s2_c;
        end
    end

    // Valid shift line alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], ctrl1_reg.valid};
    end

    // Length of A
    v2a_isqrt #(.WORD_BITS(W)) u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sqsum_reg),
        .root     (root_w)
    );

    // Root joins the payload as it leaves the square-root pipeline
    always_comb
    begin
        pay_root_c      = pay_reg[W];
        pay_root_c.root = root_w;
    end

    for (genvar k = 1; k < DEPTH; k++)
    begin : g_pay
        if (k == W + 1)
        begin : g_root
            always_ff @(posedge clk)
            begin
                if (en)
                    pay_reg[k] <= pay_root_c;
            end
        end
        else
        begin : g_plain
            always_ff @(posedge clk)
            begin
                if (en)
                    pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    // Divisor is |b| for divide, the length for normalize
    assign div_d_x = (pay_reg[W].cmd == v2a_pkg::CMD_NORM) ? root_w : pay_reg[W].mag_bx;
    assign div_d_y = (pay_reg[W].cmd == v2a_pkg::CMD_NORM) ? root_w : pay_reg[W].mag_by;

    v2a_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_x (
        .clk      (clk),
        .en       (en),
        .dividend (pay_reg[W].mag_ax),
        .divisor  (div_d_x),
        .quotient (quo_x)
    );

    v2a_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_y (
        .clk      (clk),
        .en       (en),
        .dividend (pay_reg[W].mag_ay),
        .divisor  (div_d_y),
        .quotient (quo_y)
    );

    // Final merge and result select
    assign fin = pay_reg[LAST];

    always_comb
    begin
        div_x_c   = div_lane(fin.cmd == v2a_pkg::CMD_NORM, fin.mag_ax, fin.neg_ax,
                             fin.mag_bx, fin.neg_bx, fin.root, quo_x);
        div_y_c   = div_lane(fin.cmd == v2a_pkg::CMD_NORM, fin.mag_ay, fin.neg_ay,
                             fin.mag_by, fin.neg_by, fin.root, quo_y);
        dot_mag_c = fin.dot_sum[DW-1] ? DW'(-fin.dot_sum) : DW'(fin.dot_sum);
        dot_c     = clamp_sm(fin.dot_sum[DW-1], MW'(dot_mag_c >> F));
        len_c     = clamp_sm(1'b0, MW'(fin.root));

        rx_c  = '0;
        ry_c  = '0;
        sc_c  = '0;
        dz_c  = 1'b0;
        sat_c = 1'b0;
        case (fin.cmd)
            v2a_pkg::CMD_ADD, v2a_pkg::CMD_SUB, v2a_pkg::CMD_MUL, v2a_pkg::CMD_NEG:
            begin
                rx_c  = fin.res_x;
                ry_c  = fin.res_y;
                sat_c = fin.simple_sat;
            end
            v2a_pkg::CMD_DIV, v2a_pkg::CMD_NORM:
            begin
                rx_c  = div_x_c[W-1:0];
                ry_c  = div_y_c[W-1:0];
                dz_c  = div_x_c[W+1] | div_y_c[W+1];
                sat_c = div_x_c[W] | div_y_c[W];
            end
            v2a_pkg::CMD_DOT:
            begin
                sc_c  = dot_c[W-1:0];
                sat_c = dot_c[W];
            end
            v2a_pkg::CMD_LEN:
            begin
                sc_c  = len_c[W-1:0];
                sat_c = len_c[W];
            end
            default:
            begin
                rx_c = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= FB'($signed(rx_c));
            ry_reg  <= FB'($signed(ry_c));
            sc_reg  <= FB'($signed(sc_c));
            dz_reg  <= dz_c;
            sat_reg <= sat_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sc_reg, ry_reg, rx_reg};
    assign m_tuser  = {sat_reg, dz_reg};

endmodule

>>> rtl/v2a_checker.sv
// Port-level checks for vec2_arith_unit, bound to the top level.
// Depends on v2a_pkg and vec2_arith_unit_defines.svh.
`timescale 1ns / 1ps
`include "vec2_arith_unit_defines.svh"

module v2a_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [v2a_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic [v2a_pkg::OUT_USER_BITS-1:0]  m_tuser
);

    localparam int FB = v2a_pkg::FIELD_BITS;

    // Held result stays put
    `V2A_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Empty output register never blocks the input side
    `V2A_ASSERT_SAME(a_ready_empty, clk, rst_n, !m_tvalid, s_tready)

    // A held result stalls the whole pipeline
    `V2A_ASSERT_SAME(a_stall, clk, rst_n, m_tvalid && !m_tready, !s_tready)

    // Divide by zero: no scalar, and an unclamped zero-divisor lane reads zero
    `V2A_ASSERT_SAME(a_div_zero, clk, rst_n, m_tvalid && m_tuser[v2a_pkg::OUT_DZ_BIT], (m_tdata[3*FB-1:2*FB] == '0) && (m_tuser[v2a_pkg::OUT_SAT_BIT] || (m_tdata[FB-1:0] == '0) || (m_tdata[2*FB-1:FB] == '0)))

endmodule

bind vec2_arith_unit v2a_checker u_v2a_checker (.*);
